FILE: rtl/msqrt_pkg.sv
// Package for the modular square root block: constants, sequencer states.
// No dependencies.
package msqrt_pkg;
	localparam int unsigned MOD_BITS_DEF = 63;
	localparam int unsigned MAX_TRIES_DEF = 64;
	localparam int unsigned FIELD_W = 63;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NONRES = 2'd1;
	localparam logic [1:0] ST_EXHAUST = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE, S_REDUCE, S_CHK0, S_EUL_INIT, S_EUL_STEP, S_EUL_DONE,
		S_CAND, S_W2_SUB, S_LEG_INIT, S_LEG_STEP, S_LEG_DONE,
		S_EXT_INIT, S_EXT_STEP, S_EXT_DONE, S_OUT
	} state_t;

	// multiplier job selector
	typedef enum logic [2:0] {
		J_PM_R, J_PM_B, J_T1, J_T2, J_T3, J_T4, J_T5
	} job_t;
endpackage

FILE: rtl/msqrt_mulmod.sv
// Bit-serial modular multiplier: one double-and-add step per cycle.
// Depends on msqrt_pkg.
module msqrt_mulmod import msqrt_pkg::*; #(
	parameter int unsigned MOD_BITS = MOD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MOD_BITS-1:0] a,
	input  logic [MOD_BITS-1:0] b,
	input  logic [MOD_BITS-1:0] m,
	output logic [MOD_BITS-1:0] r,
	output logic                done
);
	localparam int unsigned CW = $clog2(MOD_BITS + 1);

	logic [MOD_BITS-1:0] a_q, b_q, r_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q, done_q;
	logic [MOD_BITS:0]   dbl, dsub, sum, ssub;
	logic [MOD_BITS-1:0] r1, r2;

	always_comb begin
		dbl = {r_q, 1'b0};
		dsub = dbl - {1'b0, m};
		r1 = (dbl >= {1'b0, m}) ? dsub[MOD_BITS-1:0] : dbl[MOD_BITS-1:0];
		sum = {1'b0, r1} + {1'b0, a_q};
		ssub = sum - {1'b0, m};
		r2 = b_q[MOD_BITS-1] ? ((sum >= {1'b0, m}) ? ssub[MOD_BITS-1:0] :
			sum[MOD_BITS-1:0]) : r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(MOD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= r2;
			b_q <= {b_q[MOD_BITS-2:0], 1'b0};
		end
	end

	assign r = r_q;
	assign done = done_q;
endmodule

FILE: rtl/modular_square_root.sv
// Modular square root modulo an odd prime (Cipolla's method), top level.
// Depends on msqrt_pkg and msqrt_mulmod.
//
// Usage:
//  - Write prime_modulus through cfg_we/cfg_wdata while idle (reset value 3).
//  - Input channel: value with in_valid/in_stall. in_stall is high while an
//    item is being worked on; one item is processed at a time.
//  - Output channel: root, status with out_valid/out_stall. The result sits
//    in an output register until transferred; the sequencer takes the next
//    input meanwhile and only waits when its next result is ready.
//  - Work: each modular multiply runs on the bit-serial multiplier. Reduction
//    of the input handles one input bit at a time, then the zero check. Euler's
//    test needs up to 2*MOD_BITS multiplies, each candidate of the search
//    another 1+2*MOD_BITS, and the extension power up to 9*MOD_BITS.
//    Zero and non-residue inputs finish sooner, a modulus below 2 sooner
//    still. Most of the time is spent in the one shared bit-serial multiplier.
//  - Status: 0 root found, 1 not a residue, 2 search exhausted (root 0).
//  - Reset clears the sequencer and sets the modulus to 3.
module modular_square_root import msqrt_pkg::*; #(
	parameter int unsigned MOD_BITS = MOD_BITS_DEF,
	parameter int unsigned MAX_TRIES = MAX_TRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [FIELD_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [FIELD_W-1:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [FIELD_W-1:0] root,
	output logic [1:0]         status
);
	localparam int unsigned MW = MOD_BITS;
	localparam int unsigned TW = $clog2(MAX_TRIES + 1);
	localparam int unsigned RW = $clog2(FIELD_W + 1);

	state_t state_q, state_d;
	logic [FIELD_W-1:0] pm_q;
	logic [MW-1:0] m, x_q, half_q, i_q, w2_q;
	logic [MW-1:0] pr_q, pb_q, pe_q;          // power: result, base, exponent
	logic [MW-1:0] ra_q, rb_q, ba_q, bb_q, t1_q, t2_q, t3_q;
	logic [MW:0]   red_q;                     // reduction remainder
	logic [FIELD_W-1:0] vin_q;
	logic [RW-1:0] rcnt_q;
	logic [TW-1:0] try_q;
	logic [2:0]    job_q;
	logic [1:0]    sub_q;
	logic          ext_mode_q;
	logic          mstart;
	logic [MW-1:0] ma, mb, mr;
	logic          mdone;
	logic [FIELD_W-1:0] res_root_q;
	logic [1:0]    res_status_q;
	logic [FIELD_W-1:0] root_q;
	logic [1:0]    status_q;
	logic          ovalid_q;
	logic [MW-1:0] one_m;
	logic [MW:0]   red_sh, red_sub;
	logic [MW:0]   wsum;
	logic          in_xfer, out_xfer;

	assign m = pm_q[MW-1:0];
	assign one_m = (m == MW'(1)) ? '0 : MW'(1);
	assign in_xfer = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;
	assign in_stall = (state_q != S_IDLE);

	msqrt_mulmod #(.MOD_BITS(MW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mstart), .a(ma), .b(mb), .m(m),
		.r(mr), .done(mdone)
	);

	// reduction: restoring shift-subtract, one input bit per cycle
	always_comb begin
		red_sh = {red_q[MW-1:0], vin_q[FIELD_W-1]};
		red_sub = red_sh - {1'b0, m};
	end

	// mod-add / mod-sub helper for w2 = i*i - x
	always_comb begin
		wsum = (w2_q >= x_q) ? {1'b0, w2_q - x_q} : {1'b0, w2_q} + {1'b0, m - x_q};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_xfer) state_d = (m < MW'(2)) ? S_OUT : S_REDUCE;
			S_REDUCE: if (rcnt_q == RW'(1)) state_d = S_CHK0;
			S_CHK0: state_d = (red_q == '0) ? S_OUT : S_EUL_INIT;
			S_EUL_INIT: state_d = S_EUL_STEP;
			S_EUL_STEP: if (sub_q == 2'd0 && pe_q == '0) state_d = S_EUL_DONE;
			S_EUL_DONE: state_d = (pr_q != MW'(1)) ? S_OUT : S_CAND;
			S_CAND: if (sub_q == 2'd1 && mdone) state_d = S_W2_SUB;
			S_W2_SUB: state_d = (wsum == '0) ? S_OUT : S_LEG_INIT;
			S_LEG_INIT: state_d = S_LEG_STEP;
			S_LEG_STEP: if (sub_q == 2'd0 && pe_q == '0) state_d = S_LEG_DONE;
			S_LEG_DONE: begin
				if (pr_q == m - MW'(1)) state_d = S_EXT_INIT;
				else if (try_q == TW'(MAX_TRIES)) state_d = S_OUT;
				else state_d = S_CAND;
			end
			S_EXT_INIT: state_d = S_EXT_STEP;
			S_EXT_STEP: if (sub_q == 2'd0 && pe_q == '0) state_d = S_EXT_DONE;
			S_EXT_DONE: state_d = S_OUT;
			S_OUT: if (!ovalid_q || out_xfer) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// multiplier operand select: pr*pb, pb*pb, and extension terms
	always_comb begin
		ma = pr_q;
		mb = pb_q;
		case (job_t'(job_q))
			J_PM_R: begin ma = pr_q; mb = pb_q; end
			J_PM_B: begin ma = pb_q; mb = pb_q; end
			J_T1: begin ma = bb_q; mb = w2_q; end
			J_T2: begin ma = ext_mode_q ? rb_q : bb_q; mb = t1_q; end
			J_T3: begin ma = ext_mode_q ? ra_q : ba_q; mb = ext_mode_q ? ba_q : ba_q; end
			J_T4: begin ma = ext_mode_q ? ra_q : ba_q; mb = bb_q; end
			J_T5: begin ma = rb_q; mb = ba_q; end
			default: begin ma = pr_q; mb = pb_q; end
		endcase
	end

	function automatic logic [MW-1:0] addm(input logic [MW-1:0] a, input logic [MW-1:0] b,
			input logic [MW-1:0] mm);
		logic [MW:0] s;
		s = {1'b0, a} + {1'b0, b};
		addm = (s >= {1'b0, mm}) ? MW'(s - {1'b0, mm}) : s[MW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pm_q <= FIELD_W'(3);
			ovalid_q <= 1'b0;
			mstart <= 1'b0;
			job_q <= '0;
			sub_q <= '0;
			ext_mode_q <= 1'b0;
			try_q <= '0;
			rcnt_q <= '0;
		end else begin
			state_q <= state_d;
			mstart <= 1'b0;
			if (cfg_we) pm_q <= cfg_wdata;
			if (out_xfer) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_xfer) begin
					vin_q <= value;
					red_q <= '0;
					rcnt_q <= RW'(FIELD_W);
					res_root_q <= '0;
					res_status_q <= ST_OK;
				end
				S_REDUCE: begin
					red_q <= (red_sh >= {1'b0, m}) ? red_sub : red_sh;
					vin_q <= {vin_q[FIELD_W-2:0], 1'b0};
					rcnt_q <= rcnt_q - 1'b1;
				end
				S_CHK0: begin
					x_q <= red_q[MW-1:0];
					half_q <= (m - MW'(1)) >> 1;
					if (red_q == '0) begin
						res_root_q <= '0;
						res_status_q <= ST_OK;
					end
				end
				S_EUL_INIT, S_LEG_INIT: begin
					pr_q <= one_m;
					pb_q <= (state_q == S_EUL_INIT) ? x_q : w2_q;
					pe_q <= half_q;
					sub_q <= 2'd0;
				end
				S_EUL_STEP, S_LEG_STEP: begin
					// sub 0: pick step; 1: wait r mult; 2: wait b mult
					case (sub_q)
						2'd0: begin
							if (pe_q != '0) begin
								if (pe_q[0]) begin
									job_q <= J_PM_R; mstart <= 1'b1; sub_q <= 2'd1;
								end else begin
									job_q <= J_PM_B; mstart <= 1'b1; sub_q <= 2'd2;
								end
							end
						end
						2'd1: if (mdone) begin
							pr_q <= mr;
							job_q <= J_PM_B; mstart <= 1'b1; sub_q <= 2'd2;
						end
						2'd2: if (mdone) begin
							pb_q <= mr;
							pe_q <= pe_q >> 1;
							sub_q <= 2'd0;
						end
						default: sub_q <= 2'd0;
					endcase
				end
				S_EUL_DONE: begin
					if (pr_q != MW'(1)) begin
						res_root_q <= '0;
						res_status_q <= ST_NONRES;
					end else begin
						i_q <= (m == MW'(1)) ? '0 : MW'(1);
						try_q <= TW'(1);
						pb_q <= (m == MW'(1)) ? '0 : MW'(1);
					end
				end
				S_CAND: begin
					// w2 = i*i
					case (sub_q)
						2'd0: begin
							pr_q <= i_q; pb_q <= i_q;
							sub_q <= 2'd3;
						end
						2'd3: begin
							job_q <= J_PM_R; mstart <= 1'b1; sub_q <= 2'd1;
						end
						2'd1: if (mdone) begin
							w2_q <= mr;
							sub_q <= 2'd0;
						end
						default: sub_q <= 2'd0;
					endcase
				end
				S_W2_SUB: begin
					w2_q <= wsum[MW-1:0];
					if (wsum == '0) begin
						res_root_q <= FIELD_W'(i_q);
						res_status_q <= ST_OK;
					end
				end
				S_LEG_DONE: begin
					if (pr_q == m - MW'(1)) begin
					end else if (try_q == TW'(MAX_TRIES)) begin
						res_root_q <= '0;
						res_status_q <= ST_EXHAUST;
					end else begin
						try_q <= try_q + 1'b1;
						i_q <= addm(i_q, one_m, m);
					end
				end
				S_EXT_INIT: begin
					ra_q <= one_m; rb_q <= '0;
					ba_q <= i_q; bb_q <= one_m;
					pe_q <= half_q + MW'(1);
					sub_q <= 2'd0;
					job_q <= J_T1;
					ext_mode_q <= 1'b0;
				end
				S_EXT_STEP: begin
					// micro-sequence per exponent bit, job_q tracks progress
					if (sub_q == 2'd0) begin
						if (pe_q != '0) begin
							ext_mode_q <= pe_q[0];
							job_q <= J_T1; mstart <= 1'b1; sub_q <= 2'd1;
						end
					end else if (mdone) begin
						case (job_t'(job_q))
							J_T1: begin t1_q <= mr; job_q <= J_T2; mstart <= 1'b1; end
							J_T2: begin t2_q <= mr; job_q <= J_T3; mstart <= 1'b1; end
							J_T3: begin
								t3_q <= addm(mr, t2_q, m);
								job_q <= J_T4; mstart <= 1'b1;
							end
							J_T4: begin
								if (ext_mode_q) begin
									t2_q <= mr; job_q <= J_T5; mstart <= 1'b1;
								end else begin
									ba_q <= t3_q;
									bb_q <= addm(mr, mr, m);
									pe_q <= pe_q >> 1;
									sub_q <= 2'd0;
								end
							end
							J_T5: begin
								ra_q <= t3_q;
								rb_q <= addm(t2_q, mr, m);
								ext_mode_q <= 1'b0;
								job_q <= J_T1; mstart <= 1'b1;
							end
							default: sub_q <= 2'd0;
						endcase
					end
				end
				S_EXT_DONE: begin
					res_root_q <= FIELD_W'(ra_q);
					res_status_q <= ST_OK;
				end
				S_OUT: if (!ovalid_q || out_xfer) begin
					ovalid_q <= 1'b1;
					root_q <= res_root_q;
					status_q <= res_status_q;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign root = root_q;
	assign status = status_q;

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("input taken while busy");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != 2'd3)) else $error("bad status");
	a_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (root == '0)) else $error("root not zero");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(root))) else $error("drop");
endmodule
